### rtl/core/nfm_pkg.sv
// Shared types and constants for the flash translation map builder.
// No dependencies; compile first.
package nfm_pkg;

   localparam int MAX_BLOCKS = 1024;
   localparam int ADDR_W     = $clog2(MAX_BLOCKS);

   localparam int TAG_W     = 16;
   localparam int LOG_W     = 10;
   localparam int PHYS_W    = 10;
   localparam int COUNT_W   = 11;
   localparam int REQ_W     = 2;
   localparam int OUTCOME_W = 3;

   localparam logic [TAG_W-1:0] TAG_ALL_ONES = 16'hFFFF;

   localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd0;
   localparam logic [REQ_W-1:0] REQ_SCAN   = 2'd1;
   localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd2;

   localparam logic [OUTCOME_W-1:0] OUT_NONE   = 3'd0;
   localparam logic [OUTCOME_W-1:0] OUT_MAPPED = 3'd1;
   localparam logic [OUTCOME_W-1:0] OUT_DUP    = 3'd2;
   localparam logic [OUTCOME_W-1:0] OUT_FREE   = 3'd3;
   localparam logic [OUTCOME_W-1:0] OUT_LOOKUP = 3'd4;

   localparam logic [COUNT_W-1:0] BLOCK_COUNT_RESET = 11'd1024;

   // Result of voting the three tag copies.
   typedef struct packed {
      logic             valid;
      logic [LOG_W-1:0] logical;
   } tag_dec_type;

endpackage

### rtl/core/nfm_ifs.sv
// Handshake channels of the map builder: request, response and register write.
// Depends on nfm_pkg.
interface nfm_req_if;
   logic                         valid;
   logic                         ready;
   logic [nfm_pkg::REQ_W-1:0]    req_type;
   logic [nfm_pkg::PHYS_W-1:0]   phys_block;
   logic                         is_bad;
   logic                         read_ok;
   logic [nfm_pkg::TAG_W-1:0]    tag_copy_a;
   logic [nfm_pkg::TAG_W-1:0]    tag_copy_b;
   logic [nfm_pkg::TAG_W-1:0]    tag_copy_c;
   logic [nfm_pkg::LOG_W-1:0]    query_logical;

   modport source (output valid, req_type, phys_block, is_bad, read_ok,
                   tag_copy_a, tag_copy_b, tag_copy_c, query_logical,
                   input ready);
   modport sink (input valid, req_type, phys_block, is_bad, read_ok,
                 tag_copy_a, tag_copy_b, tag_copy_c, query_logical,
                 output ready);
endinterface

interface nfm_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [nfm_pkg::OUTCOME_W-1:0] outcome;
   logic [nfm_pkg::LOG_W-1:0]     decoded_logical;
   logic                          is_mapped;
   logic [nfm_pkg::PHYS_W-1:0]    mapped_phys;
   logic [nfm_pkg::COUNT_W-1:0]   mapped_total;
   logic [nfm_pkg::COUNT_W-1:0]   free_total;

   modport source (output valid, outcome, decoded_logical, is_mapped, mapped_phys,
                   mapped_total, free_total, input ready);
   modport sink (input valid, outcome, decoded_logical, is_mapped, mapped_phys,
                 mapped_total, free_total, output ready);
endinterface

interface nfm_csr_if;
   logic                        valid;
   logic                        ready;
   logic [nfm_pkg::COUNT_W-1:0] block_count;

   modport source (output valid, block_count, input ready);
   modport sink (input valid, block_count, output ready);
endinterface

### rtl/core/nfm_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module nfm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      // output holds until the next read
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/nfm_tag_vote.sv
// Tag voter: picks the first agreeing pair of copies and checks the winner.
// Depends on nfm_pkg.
module nfm_tag_vote (
   input  logic                       read_ok,
   input  logic [nfm_pkg::TAG_W-1:0]  tag_a,
   input  logic [nfm_pkg::TAG_W-1:0]  tag_b,
   input  logic [nfm_pkg::TAG_W-1:0]  tag_c,
   output nfm_pkg::tag_dec_type       dec
);
   import nfm_pkg::*;

   logic [TAG_W-1:0] winner;
   logic             agree;

   always_comb begin
      winner = tag_c;
      agree  = 1'b1;
      if (tag_a == tag_b) begin
         winner = tag_a;
      end else if (tag_b == tag_c) begin
         winner = tag_b;
      end else if (tag_c != tag_a) begin
         agree = 1'b0;
      end
      // odd parity or erased (all ones) tags are rejected
      dec.valid   = read_ok && agree && (winner != TAG_ALL_ONES) && !(^winner);
      dec.logical = winner[LOG_W:1];
   end

endmodule

### rtl/core/nand_ftl_map_builder_top.sv
// Flash translation map builder, top level. Holds the control FSM and counters.
// Depends on nfm_pkg, nfm_ifs, nfm_ram, nfm_tag_vote.
//
// For scan and lookup words the accept cycle reads the map
// RAM (indexed by logical number) and the free-mark RAM (indexed by physical
// block); the execute state then decides, writes back and loads the response
// register once the output register is free. A clear word sweeps both RAMs one
// entry per cycle and then answers once the output register is free. After reset
// the same clearing pass runs with no response, and no request word is
// accepted until it ends; register writes are taken at any time. A finished
// response may sit in the output register while the next request is accepted.
module nand_ftl_map_builder_top (
   input  logic        clock,
   input  logic        reset,
   nfm_req_if.sink     req_ch,
   nfm_rsp_if.source   rsp_ch,
   nfm_csr_if.sink     csr_ch
);
   import nfm_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SWEEP
   } state_type;

   localparam logic [ADDR_W-1:0] SWEEP_LAST = ADDR_W'(MAX_BLOCKS - 1);
   localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAX_BLOCKS);

   state_type            state_ff, state_in;
   logic [ADDR_W-1:0]    sweep_ff, sweep_in;
   logic                 emit_ff, emit_in;
   logic [COUNT_W-1:0]   block_count_ff, block_count_in;
   logic [COUNT_W-1:0]   mapped_ff, mapped_in;
   logic [COUNT_W-1:0]   free_ff, free_in;

   logic [REQ_W-1:0]     req_type_ff, req_type_in;
   logic [PHYS_W-1:0]    phys_ff, phys_in;
   logic                 skip_ff, skip_in;
   tag_dec_type          dec_ff, dec_in;
   logic [LOG_W-1:0]     query_ff, query_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [OUTCOME_W-1:0] outcome_ff, outcome_in;
   logic [LOG_W-1:0]     dec_out_ff, dec_out_in;
   logic                 is_mapped_ff, is_mapped_in;
   logic [PHYS_W-1:0]    mphys_ff, mphys_in;

   logic [COUNT_W-1:0]   cnt_eff;
   tag_dec_type          vote;
   logic                 req_fire;
   logic                 out_free;

   logic                 map_wr_en, map_rd_en;
   logic [ADDR_W-1:0]    map_wr_addr, map_rd_addr;
   logic [PHYS_W:0]      map_wr_data, map_rd_data;
   logic                 free_wr_en, free_rd_en;
   logic [ADDR_W-1:0]    free_wr_addr, free_rd_addr;
   logic                 free_wr_data, free_rd_data;

   nfm_tag_vote u_vote (
      .read_ok (req_ch.read_ok),
      .tag_a   (req_ch.tag_copy_a),
      .tag_b   (req_ch.tag_copy_b),
      .tag_c   (req_ch.tag_copy_c),
      .dec     (vote)
   );

   // bit PHYS_W is the valid flag, the rest the physical home
   nfm_ram #(.WIDTH(PHYS_W + 1), .DEPTH(MAX_BLOCKS)) u_map_ram (
      .clock   (clock),
      .wr_en   (map_wr_en),
      .wr_addr (map_wr_addr),
      .wr_data (map_wr_data),
      .rd_en   (map_rd_en),
      .rd_addr (map_rd_addr),
      .rd_data (map_rd_data)
   );

   nfm_ram #(.WIDTH(1), .DEPTH(MAX_BLOCKS)) u_free_ram (
      .clock   (clock),
      .wr_en   (free_wr_en),
      .wr_addr (free_wr_addr),
      .wr_data (free_wr_data),
      .rd_en   (free_rd_en),
      .rd_addr (free_rd_addr),
      .rd_data (free_rd_data)
   );

   assign cnt_eff   = (block_count_ff > COUNT_MAX) ? COUNT_MAX : block_count_ff;
   assign req_fire  = req_ch.valid && req_ch.ready;
   assign out_free  = !rsp_valid_ff || rsp_ch.ready;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.outcome         = outcome_ff;
   assign rsp_ch.decoded_logical = dec_out_ff;
   assign rsp_ch.is_mapped       = is_mapped_ff;
   assign rsp_ch.mapped_phys     = mphys_ff;
   assign rsp_ch.mapped_total    = mapped_ff;
   assign rsp_ch.free_total      = free_ff;

   always_comb begin
      state_in       = state_ff;
      sweep_in       = sweep_ff;
      emit_in        = emit_ff;
      block_count_in = block_count_ff;
      mapped_in      = mapped_ff;
      free_in        = free_ff;
      req_type_in    = req_type_ff;
      phys_in        = phys_ff;
      skip_in        = skip_ff;
      dec_in         = dec_ff;
      query_in       = query_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      outcome_in     = outcome_ff;
      dec_out_in     = dec_out_ff;
      is_mapped_in   = is_mapped_ff;
      mphys_in       = mphys_ff;

      map_rd_en    = 1'b0;
      map_rd_addr  = vote.logical[ADDR_W-1:0];
      map_wr_en    = 1'b0;
      map_wr_addr  = sweep_ff;
      map_wr_data  = '0;
      free_rd_en   = 1'b0;
      free_rd_addr = req_ch.phys_block[ADDR_W-1:0];
      free_wr_en   = 1'b0;
      free_wr_addr = sweep_ff;
      free_wr_data = 1'b0;

      if (csr_ch.valid && csr_ch.ready) begin
         block_count_in = csr_ch.block_count;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               req_type_in = req_ch.req_type;
               phys_in     = req_ch.phys_block;
               skip_in     = req_ch.is_bad ||
                             ({1'b0, req_ch.phys_block} >= cnt_eff);
               dec_in      = vote;
               query_in    = req_ch.query_logical;
               if (req_ch.req_type == REQ_CLEAR) begin
                  state_in  = ST_SWEEP;
                  sweep_in  = '0;
                  emit_in   = 1'b1;
               end else begin
                  state_in   = ST_EXEC;
                  map_rd_en  = 1'b1;
                  free_rd_en = 1'b1;
                  if (req_ch.req_type == REQ_LOOKUP) begin
                     map_rd_addr = req_ch.query_logical[ADDR_W-1:0];
                  end
               end
            end
         end

         ST_EXEC: begin
            if (out_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               outcome_in   = OUT_NONE;
               dec_out_in   = '0;
               is_mapped_in = 1'b0;
               mphys_in     = '0;
               case (req_type_ff)
                  REQ_SCAN: begin
                     if (!skip_ff) begin
                        if (dec_ff.valid) begin
                           dec_out_in = dec_ff.logical;
                        end
                        if (dec_ff.valid && ({1'b0, dec_ff.logical} < cnt_eff)) begin
                           if (!map_rd_data[PHYS_W]) begin
                              map_wr_en   = 1'b1;
                              map_wr_addr = dec_ff.logical[ADDR_W-1:0];
                              map_wr_data = {1'b1, phys_ff};
                              if (mapped_ff < cnt_eff) begin
                                 mapped_in = mapped_ff + 1'b1;
                              end
                              outcome_in = OUT_MAPPED;
                           end else begin
                              outcome_in = OUT_DUP;
                           end
                        end else begin
                           // a block already marked free is not counted again
                           if (!free_rd_data) begin
                              free_wr_en   = 1'b1;
                              free_wr_addr = phys_ff[ADDR_W-1:0];
                              free_wr_data = 1'b1;
                              if (free_ff < cnt_eff) begin
                                 free_in = free_ff + 1'b1;
                              end
                           end
                           outcome_in = OUT_FREE;
                        end
                     end
                  end
                  REQ_LOOKUP: begin
                     outcome_in = OUT_LOOKUP;
                     if (({1'b0, query_ff} < cnt_eff) && map_rd_data[PHYS_W]) begin
                        is_mapped_in = 1'b1;
                        mphys_in     = map_rd_data[PHYS_W-1:0];
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_SWEEP: begin
            map_wr_en  = 1'b1;
            free_wr_en = 1'b1;
            if (sweep_ff != SWEEP_LAST) begin
               sweep_in = sweep_ff + 1'b1;
            end else if (!emit_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               // clear word answers once the last entry is written; counters
               // drop together with the answer so a waiting word keeps its totals
               state_in     = ST_IDLE;
               emit_in      = 1'b0;
               mapped_in    = '0;
               free_in      = '0;
               rsp_valid_in = 1'b1;
               outcome_in   = OUT_NONE;
               dec_out_in   = '0;
               is_mapped_in = 1'b0;
               mphys_in     = '0;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_SWEEP;
         sweep_ff       <= '0;
         emit_ff        <= 1'b0;
         block_count_ff <= BLOCK_COUNT_RESET;
         mapped_ff      <= '0;
         free_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         sweep_ff       <= sweep_in;
         emit_ff        <= emit_in;
         block_count_ff <= block_count_in;
         mapped_ff      <= mapped_in;
         free_ff        <= free_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      req_type_ff  <= req_type_in;
      phys_ff      <= phys_in;
      skip_ff      <= skip_in;
      dec_ff       <= dec_in;
      query_ff     <= query_in;
      outcome_ff   <= outcome_in;
      dec_out_ff   <= dec_out_in;
      is_mapped_ff <= is_mapped_in;
      mphys_ff     <= mphys_in;
   end

   a_no_accept_in_sweep: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP) |-> !req_ch.ready)
      else $error("request accepted during clearing pass");

   a_mapped_bounded: assert property (@(posedge clock) disable iff (reset)
      (mapped_ff <= COUNT_MAX) && (free_ff <= COUNT_MAX))
      else $error("counter beyond block limit");

   a_mapped_step: assert property (@(posedge clock) disable iff (reset)
      (mapped_ff != $past(mapped_ff)) |->
         (mapped_ff == $past(mapped_ff) + 1 || mapped_ff == '0))
      else $error("mapped counter jumped");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_EXEC || $past(state_ff) == ST_SWEEP))
      else $error("response loaded outside execute or sweep");

   a_write_not_idle: assert property (@(posedge clock) disable iff (reset)
      (map_wr_en || free_wr_en) |-> (state_ff != ST_IDLE))
      else $error("table written while idle");

endmodule
